// ===== hw/rtl/fpd_pkg.sv =====
`timescale 1ns / 1ps

package fpd_pkg;

  localparam int DATA_W        = 16;
  localparam int QUOT_W        = 33;
  localparam int WIDTH_DEF     = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] dividend_value;
    logic signed [DATA_W-1:0] divisor_value;
  } fpd_in_t;

  typedef struct packed {
    logic signed [QUOT_W-1:0] quotient_fixed;
    logic                     exact_result;
    logic                     divide_by_zero;
  } fpd_out_t;

  typedef struct packed {
    logic negate;
    logic div_zero;
  } fpd_flags_t;

endpackage

// ===== hw/rtl/fpd_cell.sv =====
`timescale 1ns / 1ps

module fpd_cell import fpd_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  fpd_flags_t       up_flags,
  input  logic [WIDTH-1:0] up_rem,
  input  logic [WIDTH-1:0] up_num,
  input  logic [WIDTH-1:0] up_den,
  input  logic [QUOT_W-1:0] up_quo,
  output logic             dn_valid,
  input  logic             dn_ready,
  output fpd_flags_t       dn_flags,
  output logic [WIDTH-1:0] dn_rem,
  output logic [WIDTH-1:0] dn_num,
  output logic [WIDTH-1:0] dn_den,
  output logic [QUOT_W-1:0] dn_quo
);

  logic              valid_r, valid_nxt;
  fpd_flags_t        flags_r;
  logic [WIDTH-1:0]  rem_r, rem_nxt;
  logic [WIDTH-1:0]  num_r, num_nxt;
  logic [WIDTH-1:0]  den_r;
  logic [QUOT_W-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0]  trial;
  logic              ge;
  logic              load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // partial remainder stays below the divisor, so its top bit is always clear
  assign trial = {up_rem[WIDTH-2:0], up_num[WIDTH-1]};
  assign ge    = (trial >= up_den);

  always_comb begin
    rem_nxt   = ge ? (trial - up_den) : trial;
    num_nxt   = {up_num[WIDTH-2:0], 1'b0};
    quo_nxt   = {up_quo[QUOT_W-2:0], ge};
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= up_flags;
      rem_r   <= rem_nxt;
      num_r   <= num_nxt;
      den_r   <= up_den;
      quo_r   <= quo_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_flags = flags_r;
  assign dn_rem   = rem_r;
  assign dn_num   = num_r;
  assign dn_den   = den_r;
  assign dn_quo   = quo_r;

endmodule

// ===== hw/rtl/fpd_out.sv =====
`timescale 1ns / 1ps

module fpd_out import fpd_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  fpd_flags_t        up_flags,
  input  logic [WIDTH-1:0]  up_rem,
  input  logic [QUOT_W-1:0] up_quo,
  output logic              out_valid,
  input  logic              out_ready,
  output fpd_out_t          out_data
);

  logic     valid_r, valid_nxt;
  fpd_out_t data_r, data_nxt;

  assign up_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt = '0;
    if (up_flags.div_zero) begin
      data_nxt.divide_by_zero = 1'b1;
    end else begin
      data_nxt.quotient_fixed = up_flags.negate ? (QUOT_W'(0) - up_quo) : up_quo;
      data_nxt.exact_result   = (up_rem == '0);
    end
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/signed_fixed_point_divider.sv =====
`timescale 1ns / 1ps

// Signed fixed-point divider. Each item divides two two's complement operands
// (low WIDTH bits of each field) and returns the quotient scaled by 2^FRAC_BITS,
// truncated toward zero, in 33 bits two's complement, plus a zero-remainder flag
// and a divide-by-zero flag (quotient 0 then). The datapath is a row of
// WIDTH + FRAC_BITS restoring-division cells, one quotient bit per cell,
// followed by an output register. One item is accepted every cycle unless a
// stall from the result side reaches the input. Each cell and the output
// register stall independently, so bubbles are filled while the result side
// is held off.

module signed_fixed_point_divider import fpd_pkg::*; #(
  parameter int WIDTH     = WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fpd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fpd_out_t out_data
);

  localparam int NS = WIDTH + FRAC_BITS;

  logic              v_s   [NS+1];
  logic              rdy_s [NS+1];
  fpd_flags_t        f_s   [NS+1];
  logic [WIDTH-1:0]  rem_s [NS+1];
  logic [WIDTH-1:0]  num_s [NS+1];
  logic [WIDTH-1:0]  den_s [NS+1];
  logic [QUOT_W-1:0] quo_s [NS+1];

  logic signed [WIDTH-1:0] a_w, b_w;
  logic [WIDTH-1:0]        mag_a, mag_b;

  assign a_w   = WIDTH'(in_data.dividend_value);
  assign b_w   = WIDTH'(in_data.divisor_value);
  assign mag_a = a_w[WIDTH-1] ? (WIDTH'(0) - a_w) : a_w;
  assign mag_b = b_w[WIDTH-1] ? (WIDTH'(0) - b_w) : b_w;

  assign v_s[0]            = in_valid;
  assign in_ready          = rdy_s[0];
  assign f_s[0].negate     = a_w[WIDTH-1] ^ b_w[WIDTH-1];
  assign f_s[0].div_zero   = (b_w == '0);
  assign rem_s[0]          = '0;
  assign num_s[0]          = mag_a;
  assign den_s[0]          = mag_b;
  assign quo_s[0]          = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    fpd_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_s[i]),
      .up_ready (rdy_s[i]),
      .up_flags (f_s[i]),
      .up_rem   (rem_s[i]),
      .up_num   (num_s[i]),
      .up_den   (den_s[i]),
      .up_quo   (quo_s[i]),
      .dn_valid (v_s[i+1]),
      .dn_ready (rdy_s[i+1]),
      .dn_flags (f_s[i+1]),
      .dn_rem   (rem_s[i+1]),
      .dn_num   (num_s[i+1]),
      .dn_den   (den_s[i+1]),
      .dn_quo   (quo_s[i+1])
    );
  end

  fpd_out #(.WIDTH(WIDTH)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v_s[NS]),
    .up_ready  (rdy_s[NS]),
    .up_flags  (f_s[NS]),
    .up_rem    (rem_s[NS]),
    .up_quo    (quo_s[NS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/fpd_checker.sv =====
`timescale 1ns / 1ps

module fpd_checker import fpd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input fpd_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input fpd_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |->
      out_data.quotient_fixed == '0 && !out_data.exact_result)
    else $error("divide by zero with nonzero quotient or exact flag");

  a_first_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid, 2) || $past(in_ready, 2)
      || $past(in_valid, 3) || $past(in_ready, 3))
    else $error("result appeared without pipeline activity");

endmodule

bind signed_fixed_point_divider fpd_checker u_fpd_checker (.*);

// ===== tb/signed_fixed_point_divider_tb.sv =====
`timescale 1ns / 1ps

module signed_fixed_point_divider_tb;
  import fpd_pkg::*;

  localparam int DIV_LATENCY = WIDTH_DEF + FRAC_BITS_DEF + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  fpd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fpd_out_t out_data;

  fpd_out_t pending_quotients[$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  bit       sender_gaps    = 1'b0;
  bit       sink_stalls    = 1'b0;
  bit       hold_request   = 1'b0;

  signed_fixed_point_divider dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic fpd_out_t divide_fixed(fpd_in_t item);
    fpd_out_t    res;
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic [63:0] rem;
    logic [63:0] quo;
    logic        num_neg;
    logic        den_neg;
    logic        next_bit;
    num_mag = 64'(item.dividend_value[WIDTH_DEF-1:0]);
    den_mag = 64'(item.divisor_value[WIDTH_DEF-1:0]);
    num_neg = item.dividend_value[WIDTH_DEF-1];
    den_neg = item.divisor_value[WIDTH_DEF-1];
    if (num_neg) num_mag = (64'd1 << WIDTH_DEF) - num_mag;
    if (den_neg) den_mag = (64'd1 << WIDTH_DEF) - den_mag;
    res = '0;
    if (den_mag == 0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    rem = '0;
    quo = '0;
    for (int i = WIDTH_DEF + FRAC_BITS_DEF - 1; i >= 0; i--) begin
      next_bit = 1'b0;
      if (i >= FRAC_BITS_DEF) next_bit = num_mag[i - FRAC_BITS_DEF];
      rem = {rem[62:0], next_bit};
      quo = quo << 1;
      if (rem >= den_mag) begin
        rem    = rem - den_mag;
        quo[0] = 1'b1;
      end
    end
    if (num_neg ^ den_neg) quo = -quo;
    res.quotient_fixed = quo[QUOT_W-1:0];
    res.exact_result   = (rem == 0);
    return res;
  endfunction

  function automatic fpd_in_t random_operands();
    fpd_in_t item;
    int      pick;
    int      den;
    int      quo;
    int      corner[6] = '{-32768, -32767, -1, 0, 1, 32767};
    pick = $urandom_range(0, 9);
    item.dividend_value = 16'($urandom);
    item.divisor_value  = 16'($urandom);
    case (pick)
      0, 1, 2, 3: begin
      end
      4, 5: begin
        item.divisor_value = 16'($urandom_range(0, 16) - 8);
      end
      6, 7: begin
        den = $urandom_range(1, 255);
        quo = $urandom_range(0, 32767 / den);
        if ($urandom_range(0, 1)) quo = -quo;
        if ($urandom_range(0, 1)) den = -den;
        item.dividend_value = 16'(den * quo);
        item.divisor_value  = 16'(den);
      end
      8: begin
        item.dividend_value = 16'(corner[$urandom_range(0, 5)]);
        item.divisor_value  = 16'(corner[$urandom_range(0, 5)]);
      end
      default: begin
        item.divisor_value = '0;
      end
    endcase
    return item;
  endfunction

  task automatic send_division(fpd_in_t item);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_quotients.push_back(divide_fixed(item));
  endtask

  task automatic run_directed_cases();
    fpd_in_t item;
    int      ops[24][2] = '{
      '{32767, 1}, '{-32768, 1}, '{-32768, -1}, '{32767, -1},
      '{-32768, 32767}, '{32767, -32768}, '{-32768, -32768}, '{1, 32767},
      '{-1, 32767}, '{1, -32768}, '{0, 7}, '{0, -32768},
      '{7, 3}, '{-7, 3}, '{7, -2}, '{-7, -2},
      '{100, 0}, '{-32768, 0}, '{0, 0}, '{-1, 0},
      '{32767, 32767}, '{1, 3}, '{21845, -3}, '{-21846, 5}
    };
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    foreach (ops[i]) begin
      item.dividend_value = 16'(ops[i][0]);
      item.divisor_value  = 16'(ops[i][1]);
      send_division(item);
    end
  endtask

  task automatic run_random_mix();
    for (int n = 0; n < 780; n++) begin
      if (n % 100 == 0) begin
        sender_gaps = $urandom_range(0, 3) != 0;
        sink_stalls = $urandom_range(0, 3) != 0;
      end
      send_division(random_operands());
    end
  endtask

  task automatic run_backpressure();
    sender_gaps  = 1'b0;
    sink_stalls  = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 100; n++) send_division(random_operands());
  endtask

  task automatic run_steady_stream();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    for (int n = 0; n < 150; n++) send_division(random_operands());
  endtask

  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    fpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_quotients.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: quotient %0d exact %0b div0 %0b",
                   out_data.quotient_fixed, out_data.exact_result,
                   out_data.divide_by_zero);
      end else begin
        want = pending_quotients.pop_front();
        if (out_data.quotient_fixed !== want.quotient_fixed ||
            out_data.exact_result !== want.exact_result ||
            out_data.divide_by_zero !== want.divide_by_zero) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected q %0d exact %0b div0 %0b, got q %0d exact %0b div0 %0b",
                     want.quotient_fixed, want.exact_result, want.divide_by_zero,
                     out_data.quotient_fixed, out_data.exact_result,
                     out_data.divide_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_cases();
    run_random_mix();
    run_backpressure();
    run_steady_stream();
    in_valid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DIV_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_quotients.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_cell.sv
hw/rtl/fpd_out.sv
hw/rtl/signed_fixed_point_divider.sv
hw/rtl/fpd_checker.sv
tb/signed_fixed_point_divider_tb.sv
